FILE: hw/rtl/wrrps_pkg.sv
// Shared types and constants for the weighted round-robin path selector.
package wrrps_pkg;

  // Fixed field widths.
  localparam int FUNC_W   = 2;
  localparam int DEST_W   = 6;
  localparam int SLOT_W   = 3;
  localparam int WEIGHT_W = 16;
  localparam int PCNT_W   = 4;
  localparam int SEL_W    = 3;
  localparam int COUNT_W  = 32;
  localparam int PROD_W   = COUNT_W + WEIGHT_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Item function codes.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_SELECT = 2'd0,
    FUNC_WRITE  = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_CMP,
    ST_WB,
    ST_DONE
  } state_t;

  // One path slot as read from the two memories.
  typedef struct packed {
    logic [WEIGHT_W-1:0] w;
    logic [COUNT_W-1:0]  c;
  } cand_t;

endpackage

FILE: hw/rtl/wrrps_ifs.sv
// Request and response channel interfaces of the path selector.
interface wrrps_req_if;
  import wrrps_pkg::*;

  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [DEST_W-1:0]   dest;
  logic [SLOT_W-1:0]   path_slot;
  logic [WEIGHT_W-1:0] weight;
  logic [PCNT_W-1:0]   path_count;

  modport source (output valid, func, dest, path_slot, weight, path_count,
                  input ready);
  modport sink   (input valid, func, dest, path_slot, weight, path_count,
                  output ready);
endinterface

interface wrrps_rsp_if;
  import wrrps_pkg::*;

  logic             valid;
  logic             ready;
  logic             path_valid;
  logic [SEL_W-1:0] path_idx;

  modport source (output valid, path_valid, path_idx, input ready);
  modport sink   (input valid, path_valid, path_idx, output ready);
endinterface

FILE: hw/rtl/wrrps_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module wrrps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/wrrps_ratio.sv
// Cross-multiplication stage that compares a candidate ratio with the best so far.
module wrrps_ratio (
  input  logic             clk,
  input  logic             load,
  input  wrrps_pkg::cand_t cand_in,
  input  wrrps_pkg::cand_t best,
  output wrrps_pkg::cand_t cand,
  output logic             less
);
  import wrrps_pkg::*;

  logic [PROD_W-1:0] p_cand;
  logic [PROD_W-1:0] p_best;

  // Register both products and the candidate itself.
  always_ff @(posedge clk) begin
    if (load) begin
      cand   <= cand_in;
      p_cand <= PROD_W'(cand_in.c) * PROD_W'(best.w);
      p_best <= PROD_W'(best.c) * PROD_W'(cand_in.w);
    end
  end

  // Candidate count/weight is strictly below the best count/weight.
  assign less = p_cand < p_best;

endmodule

FILE: hw/rtl/weighted_round_robin_path_select_core.sv
// Top level of the per-destination weighted round-robin path selector.
//
//   channel  dir  fields                                     transfer when
//   req      in   func, dest, path_slot, weight, path_count  valid && ready
//   rsp      out  path_valid, path_idx                       valid && ready
//   cfg      in   cfg_wr_data (own_router)                   cfg_wr_en
//
// A select over n paths (n of two or more) reads the weight and counter memories,
// then runs a multiply-then-compare step for each path and writes back the counter
// of the chosen path; other items but a clear go straight to the done state. A clear
// item sweeps the counter memory one entry a cycle, and after reset the same sweep
// runs before the first request transfer. One item is in work at a time; a stalled
// response holds the finished item and the next request waits until the result is
// taken.
module weighted_round_robin_path_select_core #(
  parameter int MAX_ROUTERS = 64,
  parameter int MAX_PATHS   = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [wrrps_pkg::DEST_W-1:0] cfg_wr_data,
  wrrps_req_if.sink                   req,
  wrrps_rsp_if.source                 rsp
);
  import wrrps_pkg::*;

  localparam int SLOTS  = MAX_ROUTERS * MAX_PATHS;
  localparam int ADDR_W = $clog2(SLOTS);
  localparam int NMAX   = (MAX_PATHS < 15) ? MAX_PATHS : 15;
  localparam int IDX_W  = $clog2(NMAX);

  state_t state;
  state_t state_next;

  // Control registers.
  logic [ADDR_W-1:0] sweep;
  logic              clr_item;
  logic              rsp_valid;
  logic [DEST_W-1:0] own_router;

  // Item registers.
  logic [ADDR_W-1:0] base;
  logic [IDX_W-1:0]  n_last;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  sel;
  logic              found;
  cand_t             best;
  logic [COUNT_W-1:0] c0;
  logic              res_pv;
  logic [SEL_W-1:0]  res_sel;
  logic              rsp_pv;
  logic [SEL_W-1:0]  rsp_sel;

  // Memory ports.
  logic                w_we;
  logic [ADDR_W-1:0]   w_waddr;
  logic [WEIGHT_W-1:0] w_rdata;
  logic                c_we;
  logic [ADDR_W-1:0]   c_waddr;
  logic [COUNT_W-1:0]  c_wdata;
  logic [COUNT_W-1:0]  c_rdata;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;

  logic              req_ready;
  logic              load;
  logic              out_load;
  logic              less;
  cand_t             cand;
  cand_t             cand_in;

  // Request decode.
  func_t             func;
  logic              dest_ok;
  logic              slot_ok;
  logic              sel_ok;
  logic [PCNT_W-1:0] n_eff;
  logic [ADDR_W-1:0] base_in;
  logic [COUNT_W-1:0] tgt;

  assign func    = func_t'(req.func);
  assign dest_ok = int'(req.dest) < MAX_ROUTERS;
  assign slot_ok = int'(req.path_slot) < MAX_PATHS;
  assign n_eff   = (int'(req.path_count) > MAX_PATHS) ? PCNT_W'(MAX_PATHS) : req.path_count;
  assign sel_ok  = dest_ok && (req.dest != own_router) && (n_eff != '0);
  assign base_in = ADDR_W'(req.dest) * ADDR_W'(MAX_PATHS);
  assign w_waddr = base_in + ADDR_W'(req.path_slot);
  assign tgt     = found ? best.c : c0;
  assign cand_in = '{w: w_rdata, c: c_rdata};

  // Weight and counter memories share one read address.
  wrrps_ram #(.WIDTH(WEIGHT_W), .DEPTH(SLOTS)) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (req.weight),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (w_rdata)
  );

  wrrps_ram #(.WIDTH(COUNT_W), .DEPTH(SLOTS)) u_count_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (c_rdata)
  );

  wrrps_ratio u_ratio (
    .clk     (clk),
    .load    (load),
    .cand_in (cand_in),
    .best    (best),
    .cand    (cand),
    .less    (less)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and memory controls.
  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    w_we       = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = base_in;
    c_we       = 1'b0;
    c_waddr    = sweep;
    c_wdata    = '0;
    load       = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        c_we = 1'b1;
        if (sweep == ADDR_W'(SLOTS - 1)) begin
          state_next = clr_item ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req.valid) begin
          unique case (func)
            FUNC_SELECT: begin
              if (sel_ok && (n_eff > PCNT_W'(1))) begin
                rd_en      = 1'b1;
                state_next = ST_MUL;
              end else begin
                state_next = ST_DONE;
              end
            end
            FUNC_WRITE: begin
              w_we       = dest_ok && slot_ok;
              state_next = ST_DONE;
            end
            FUNC_CLEAR: begin
              state_next = ST_CLEAR;
            end
            FUNC_NONE: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end
      ST_MUL: begin
        // Products of this path; fetch the next path meanwhile.
        load    = 1'b1;
        rd_en   = (idx != n_last);
        rd_addr = base + ADDR_W'(idx) + ADDR_W'(1);
        state_next = ST_CMP;
      end
      ST_CMP: begin
        state_next = (idx == n_last) ? ST_WB : ST_MUL;
      end
      ST_WB: begin
        c_we       = 1'b1;
        c_waddr    = base + ADDR_W'(sel);
        c_wdata    = (tgt == COUNT_MAX) ? tgt : tgt + COUNT_W'(1);
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!rsp_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign req.ready = req_ready;

  // Control registers: sweep, response valid and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep      <= '0;
      clr_item   <= 1'b0;
      rsp_valid  <= 1'b0;
      own_router <= '0;
    end else begin
      if (cfg_wr_en) begin
        own_router <= cfg_wr_data;
      end
      if (state == ST_CLEAR) begin
        sweep <= (sweep == ADDR_W'(SLOTS - 1)) ? '0 : sweep + ADDR_W'(1);
      end
      if (req_ready && req.valid) begin
        clr_item <= (func == FUNC_CLEAR);
      end
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Item datapath: running best and result.
  always_ff @(posedge clk) begin
    if (req_ready && req.valid) begin
      base    <= base_in;
      n_last  <= IDX_W'(n_eff - PCNT_W'(1));
      idx     <= '0;
      sel     <= '0;
      found   <= 1'b0;
      best    <= '0;
      res_pv  <= (func == FUNC_SELECT) && sel_ok;
      res_sel <= '0;
    end
    if (state == ST_CMP) begin
      if ((cand.w != '0) && (!found || less)) begin
        found <= 1'b1;
        best  <= cand;
        sel   <= idx;
      end
      if (idx == '0) begin
        c0 <= cand.c;
      end
      if (idx != n_last) begin
        idx <= idx + IDX_W'(1);
      end
    end
    if (state == ST_WB) begin
      res_sel <= SEL_W'(sel);
    end
    if (out_load) begin
      rsp_pv  <= res_pv;
      rsp_sel <= res_sel;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.path_valid = rsp_pv;
  assign rsp.path_idx   = rsp_sel;

  // An empty result never names a path.
  a_empty_sel_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.path_valid |-> rsp.path_idx == '0)
    else $error("empty result carries a nonzero path");

  // The saturating increment never wraps a counter to zero.
  a_no_wrap: assert property (@(posedge clk) disable iff (rst)
    state == ST_WB |-> c_wdata != '0)
    else $error("counter write-back wrapped");

  // The path index stays within the path count of the item.
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL || state == ST_CMP) |-> idx <= n_last)
    else $error("path index beyond path count");

  // No request transfer while a counter write is in progress.
  a_no_accept_on_write: assert property (@(posedge clk) disable iff (rst)
    c_we |-> !req.ready)
    else $error("request accepted during counter write");

endmodule

FILE: tb/tb_weighted_round_robin_path_select_core.sv
// Self-checking testbench for the weighted round-robin path selector core.
module tb_weighted_round_robin_path_select_core;
  import wrrps_pkg::*;

  localparam int ROUTERS     = 64;
  localparam int PATHS       = 8;
  localparam int SETTLE      = ROUTERS * PATHS + 8;
  localparam int STALL_LIMIT = 6000;
  localparam int HOLD_AT     = 1000;
  localparam int HOLD_LEN    = 400;

  // One request item and one path decision.
  typedef struct {
    func_t               func;
    logic [DEST_W-1:0]   dest;
    logic [SLOT_W-1:0]   slot;
    logic [WEIGHT_W-1:0] weight;
    logic [PCNT_W-1:0]   count;
  } path_req_t;

  typedef struct {
    logic             path_valid;
    logic [SEL_W-1:0] path_idx;
  } path_pick_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [DEST_W-1:0] cfg_wr_data = '0;

  logic      req_valid = 1'b0;
  path_req_t req_item = '{FUNC_NONE, '0, '0, '0, '0};
  logic      rsp_ready = 1'b0;

  wrrps_req_if req_ch ();
  wrrps_rsp_if rsp_ch ();

  assign req_ch.valid      = req_valid;
  assign req_ch.func       = req_item.func;
  assign req_ch.dest       = req_item.dest;
  assign req_ch.path_slot  = req_item.slot;
  assign req_ch.weight     = req_item.weight;
  assign req_ch.path_count = req_item.count;
  assign rsp_ch.ready      = rsp_ready;

  weighted_round_robin_path_select_core #(
    .MAX_ROUTERS(ROUTERS),
    .MAX_PATHS  (PATHS)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .req        (req_ch),
    .rsp        (rsp_ch)
  );

  always #5 clk = ~clk;

  // Mirror of the selector state used for prediction.
  logic [WEIGHT_W-1:0] weight_mirror [ROUTERS*PATHS] = '{default: '0};
  logic [COUNT_W-1:0]  usage_mirror  [ROUTERS*PATHS] = '{default: '0};
  logic [DEST_W-1:0]   own_mirror = '0;
  // Which weight slots the stimulus has loaded so far.
  logic [PATHS-1:0]    weight_loaded [ROUTERS] = '{default: '0};

  path_req_t  pending_requests [$];
  path_pick_t expected_picks [$];

  int req_xfers = 0;
  int rsp_xfers = 0;
  int mismatches = 0;
  int stall_cycles = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;
  logic quiet;

  // No idling on either side while this window of transfers is under way.
  assign quiet = (req_xfers >= 400) && (req_xfers < 800);

  // Apply one item to the mirror and return the path decision it produces.
  function automatic path_pick_t predict_pick(path_req_t it);
    path_pick_t          pick;
    int unsigned         n;
    int unsigned         base;
    int unsigned         best;
    logic                found;
    logic [PROD_W-1:0]   best_c;
    logic [PROD_W-1:0]   best_w;
    logic [PROD_W-1:0]   c;
    logic [PROD_W-1:0]   w;
    pick.path_valid = 1'b0;
    pick.path_idx   = '0;
    case (it.func)
      FUNC_WRITE: begin
        weight_mirror[it.dest*PATHS + it.slot] = it.weight;
      end
      FUNC_CLEAR: begin
        foreach (usage_mirror[k]) usage_mirror[k] = '0;
      end
      FUNC_SELECT: begin
        n = (it.count > PATHS) ? PATHS : it.count;
        if (it.dest != own_mirror && n != 0) begin
          pick.path_valid = 1'b1;
          if (n > 1) begin
            base = it.dest * PATHS;
            found = 1'b0;
            best = 0;
            best_c = '0;
            best_w = '0;
            // Least count/weight ratio wins, first on ties; zero weights sit out.
            for (int i = 0; i < n; i++) begin
              w = PROD_W'(weight_mirror[base + i]);
              c = PROD_W'(usage_mirror[base + i]);
              if (w != 0 && (!found || c * best_w < best_c * w)) begin
                found = 1'b1;
                best_c = c;
                best_w = w;
                best = i;
              end
            end
            if (usage_mirror[base + best] != COUNT_MAX) begin
              usage_mirror[base + best] = usage_mirror[base + best] + COUNT_W'(1);
            end
            pick.path_idx = best[SEL_W-1:0];
          end
        end
      end
      default: begin
      end
    endcase
    return pick;
  endfunction

  // Number of leading slots of a destination whose weights are loaded.
  function automatic int loaded_prefix(logic [DEST_W-1:0] d);
    int n = 0;
    while (n < PATHS && weight_loaded[d][n]) n++;
    return n;
  endfunction

  // Weights lean toward small values so that ratios collide and ties occur.
  function automatic logic [WEIGHT_W-1:0] rand_weight();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    if (r < 50) return WEIGHT_W'($urandom_range(1, 8));
    if (r < 70) return WEIGHT_W'($urandom_range(50, 300));
    return WEIGHT_W'($urandom_range(0, 65535));
  endfunction

  // A path count that never makes the block read a weight nobody loaded.
  function automatic logic [PCNT_W-1:0] rand_count(logic [DEST_W-1:0] d);
    int n;
    int r;
    n = loaded_prefix(d);
    r = $urandom_range(0, 99);
    if (d == own_mirror) return PCNT_W'($urandom_range(0, 15));
    if (n < 2 || r < 12) return PCNT_W'($urandom_range(0, 1));
    if (n == PATHS && r < 30) return PCNT_W'($urandom_range(PATHS + 1, 15));
    return PCNT_W'($urandom_range(2, n));
  endfunction

  function automatic void push_item(func_t f, logic [DEST_W-1:0] d, logic [SLOT_W-1:0] s,
                                    logic [WEIGHT_W-1:0] w, logic [PCNT_W-1:0] c);
    path_req_t it;
    it.func = f;
    it.dest = d;
    it.slot = s;
    it.weight = w;
    it.count = c;
    if (f == FUNC_WRITE) weight_loaded[d][s] = 1'b1;
    pending_requests.insert(pending_requests.size(), it);
  endfunction

  function automatic void push_select(logic [DEST_W-1:0] d, logic [PCNT_W-1:0] c);
    push_item(FUNC_SELECT, d, SLOT_W'($urandom_range(0, 7)),
              WEIGHT_W'($urandom_range(0, 65535)), c);
  endfunction

  function automatic void push_weight(logic [DEST_W-1:0] d, logic [SLOT_W-1:0] s,
                                      logic [WEIGHT_W-1:0] w);
    push_item(FUNC_WRITE, d, s, w, PCNT_W'($urandom_range(0, 15)));
  endfunction

  // Wait for every item to finish, then let the block settle.
  task automatic drain();
    while (pending_requests.size() != 0 || req_valid || expected_picks.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_own_router(logic [DEST_W-1:0] id);
    drain();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= id;
    own_mirror = id;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Weight loads for a few target destinations, then selects that work against them.
  task automatic fill_random(int n_items);
    logic [DEST_W-1:0] focus [6];
    int r;
    int len;
    int k;
    k = 0;
    while (pending_requests.size() < n_items) begin
      if (k % 150 == 0) begin
        foreach (focus[j]) focus[j] = DEST_W'($urandom_range(0, ROUTERS - 1));
        if ($urandom_range(0, 1) == 0) focus[5] = own_mirror;
        for (int j = 0; j < 5; j++) begin
          len = ($urandom_range(0, 9) < 7) ? PATHS : $urandom_range(2, PATHS - 1);
          for (int s = 0; s < len; s++) push_weight(focus[j], SLOT_W'(s), rand_weight());
        end
      end
      k++;
      r = $urandom_range(0, 99);
      if (r < 10) begin
        push_weight((r < 8) ? focus[$urandom_range(0, 5)]
                            : DEST_W'($urandom_range(0, ROUTERS - 1)),
                    SLOT_W'($urandom_range(0, 7)), rand_weight());
      end else if (r < 12) begin
        push_item(FUNC_CLEAR, DEST_W'($urandom_range(0, 63)), SLOT_W'($urandom_range(0, 7)),
                  WEIGHT_W'($urandom_range(0, 65535)), PCNT_W'($urandom_range(0, 15)));
      end else if (r < 14) begin
        push_item(FUNC_NONE, DEST_W'($urandom_range(0, 63)), SLOT_W'($urandom_range(0, 7)),
                  WEIGHT_W'($urandom_range(0, 65535)), PCNT_W'($urandom_range(0, 15)));
      end else if (r < 20) begin
        begin : any_dest
          logic [DEST_W-1:0] d;
          d = DEST_W'($urandom_range(0, ROUTERS - 1));
          push_select(d, rand_count(d));
        end
      end else begin
        begin : focus_dest
          logic [DEST_W-1:0] d;
          d = focus[$urandom_range(0, 5)];
          push_select(d, rand_count(d));
        end
      end
    end
  endtask

  // Stimulus: directed cases first, then random phases under different router ids.
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    set_own_router(6'd5);
    // Ratio order, zero weight skipped, then the heavy path takes over.
    push_weight(6'd63, 3'd0, 16'd100);
    push_weight(6'd63, 3'd1, 16'd0);
    push_weight(6'd63, 3'd2, 16'hFFFF);
    push_select(6'd63, 4'd3);
    push_select(6'd63, 4'd3);
    // All weights zero falls back to path zero.
    push_weight(6'd0, 3'd0, 16'd0);
    push_weight(6'd0, 3'd1, 16'd0);
    push_select(6'd0, 4'd2);
    // Own destination, no paths and a single path.
    push_select(6'd5, 4'd5);
    push_select(6'd63, 4'd0);
    push_select(6'd63, 4'd1);
    // Full row, path count beyond the slot count saturates.
    for (int s = 0; s < PATHS; s++) begin
      push_weight(6'd7, SLOT_W'(s), (s == 7) ? 16'hFFFF : 16'(s + 1));
    end
    push_select(6'd7, 4'd15);
    push_select(6'd7, 4'd8);
    // Clear, the unused function code, and a select after the clear.
    push_item(FUNC_CLEAR, 6'd0, 3'd0, 16'd0, 4'd0);
    push_item(FUNC_NONE, 6'd42, 3'd7, 16'hFFFF, 4'd15);
    push_select(6'd63, 4'd3);

    set_own_router(6'd0);
    fill_random(600);
    set_own_router(6'd63);
    fill_random(600);
    set_own_router(DEST_W'($urandom_range(1, 62)));
    fill_random(625);

    drain();
    if (mismatches == 0 && expected_picks.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Request driver: holds each item until its transfer, idles at random.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ch.ready) begin
        expected_picks.insert(expected_picks.size(), predict_pick(req_item));
        req_xfers <= req_xfers + 1;
      end
      if (!req_valid || req_ch.ready) begin
        if (pending_requests.size() != 0 && (quiet || $urandom_range(0, 99) >= 36)) begin
          req_item <= pending_requests.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor: checks each transfer against the oldest expected pick.
  always @(posedge clk) begin : response_check
    path_pick_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_ready && rsp_ch.valid) begin
        rsp_xfers <= rsp_xfers + 1;
        if (expected_picks.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual valid %0d path %0d",
                   $time, rsp_ch.path_valid, rsp_ch.path_idx);
          mismatches++;
        end else begin
          want = expected_picks.pop_front();
          if (rsp_ch.path_valid !== want.path_valid) begin
            $display("%0t: path_valid mismatch, expected %0d, actual %0d",
                     $time, want.path_valid, rsp_ch.path_valid);
            mismatches++;
          end
          if (rsp_ch.path_idx !== want.path_idx) begin
            $display("%0t: path_idx mismatch, expected %0d, actual %0d",
                     $time, want.path_idx, rsp_ch.path_idx);
            mismatches++;
          end
        end
      end
      // One long hold-off lets the block fill up and stall its request side.
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        rsp_ready <= 1'b0;
      end else if (!hold_done && rsp_xfers == HOLD_AT) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_LEN;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= quiet || ($urandom_range(0, 99) >= 36);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ch.ready) || (rsp_ready && rsp_ch.valid)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

endmodule

FILE: files.f
hw/rtl/wrrps_pkg.sv
hw/rtl/wrrps_ifs.sv
hw/rtl/wrrps_ram.sv
hw/rtl/wrrps_ratio.sv
hw/rtl/weighted_round_robin_path_select_core.sv
tb/tb_weighted_round_robin_path_select_core.sv
